@@ rtl/rtq_pkg.sv @@
// Shared constants, request codes and control structs of the rectangle table query block.
// No dependencies; every other file of the block imports this package.
package rtq_pkg;

	localparam int MAX_BOXES_DEF  = 64;
	localparam int COORD_BITS_DEF = 16;
	localparam int COUNT_W        = 7;
	localparam int IDX_W          = 6;
	localparam int REQ_W          = 2;

	localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_OVERLAP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CONTAIN = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic write_en;
		logic query_start;
		logic scan_run;
		logic result_load;
	} rtq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_done;
	} rtq_status_t;

endpackage

@@ rtl/rtq_ifs.sv @@
// Valid/ready channel interfaces: request items, result items and the box_count write port.
// Depends on rtq_pkg for field widths.
interface rtq_req_if import rtq_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [REQ_W-1:0]             req_type;
	logic [IDX_W-1:0]             entry_index;
	logic signed [COORD_BITS-1:0] left_edge;
	logic signed [COORD_BITS-1:0] top_edge;
	logic signed [COORD_BITS-1:0] right_edge;
	logic signed [COORD_BITS-1:0] bottom_edge;

	modport source (output valid, req_type, entry_index, left_edge, top_edge, right_edge,
		bottom_edge, input ready);
	modport sink (input valid, req_type, entry_index, left_edge, top_edge, right_edge,
		bottom_edge, output ready);
endinterface

interface rtq_res_if import rtq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             hit;
	logic [IDX_W-1:0] hit_index;

	modport source (output valid, hit, hit_index, input ready);
	modport sink (input valid, hit, hit_index, output ready);
endinterface

interface rtq_cfg_if import rtq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/rectangle_table_query.sv @@
// Rectangle table query: box table with first-match overlap and containment search.
// A write item is taken while idle; a query's result is loaded after its scan ends, at the
// first match or after N = min(box_count, MAX_BOXES) entries, one table entry read per cycle.
// The single memory read port scan takes no new item until the result is loaded.
// Reset (arst_n low, asynchronous): box_count clears to 0, controller idles, no result
// pending; table contents stay undefined until written.
module rectangle_table_query import rtq_pkg::*; #(
	parameter int MAX_BOXES  = MAX_BOXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	rtq_req_if.sink  req,
	rtq_res_if.source res,
	rtq_cfg_if.sink  cfg
);

	rtq_cmd_t    cmd;
	rtq_status_t status;

	// The box_count register takes a write in any cycle
	assign cfg.ready = 1'b1;

	// Controller: accept items only while idle, sequence the scan, own the result valid
	rtq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.out_valid   (res.valid),
		.out_ready   (res.ready),
		.status      (status),
		.cmd         (cmd)
	);

	// Datapath: table memory, query registers, scan compare, result registers
	rtq_dpath #(
		.MAX_BOXES  (MAX_BOXES),
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.req_type    (req.req_type),
		.entry_index (req.entry_index),
		.left_edge   (req.left_edge),
		.top_edge    (req.top_edge),
		.right_edge  (req.right_edge),
		.bottom_edge (req.bottom_edge),
		.hit         (res.hit),
		.hit_index   (res.hit_index)
	);

endmodule

@@ rtl/rtq_ctrl.sv @@
// Controller for the rectangle table query block: request handshake, scan sequencing, result valid.
// Depends on rtq_pkg for request codes and the command/status structs.
module rtq_ctrl import rtq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [REQ_W-1:0] in_req_type,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  rtq_status_t      status,
	output rtq_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   accept;
	logic   is_query;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = res_valid_q;
	assign accept    = in_valid && in_ready;
	assign is_query  = (in_req_type == REQ_OVERLAP) || (in_req_type == REQ_CONTAIN);
	assign out_free  = !res_valid_q || out_ready;

	always_comb begin
		cmd             = '0;
		cmd.write_en    = accept && (in_req_type == REQ_WRITE);
		cmd.query_start = accept && is_query;
		cmd.scan_run    = (state_q == ST_SCAN);
		cmd.result_load = out_free && (((state_q == ST_SCAN) && status.scan_done) ||
			(state_q == ST_HOLD));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			// result register: load wins over drain
			if (cmd.result_load) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.query_start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.scan_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/rtq_dpath.sv @@
// Datapath for the rectangle table query block: box memory, query registers, scan pointer,
// compare stage and result registers. Depends on rtq_pkg.
module rtq_dpath import rtq_pkg::*; #(
	parameter int MAX_BOXES  = MAX_BOXES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rtq_cmd_t                     cmd,
	output rtq_status_t                  status,
	input  logic                         cfg_we,
	input  logic [COUNT_W-1:0]           cfg_data,
	input  logic [REQ_W-1:0]             req_type,
	input  logic [IDX_W-1:0]             entry_index,
	input  logic signed [COORD_BITS-1:0] left_edge,
	input  logic signed [COORD_BITS-1:0] top_edge,
	input  logic signed [COORD_BITS-1:0] right_edge,
	input  logic signed [COORD_BITS-1:0] bottom_edge,
	output logic                         hit,
	output logic [IDX_W-1:0]             hit_index
);

	localparam int AW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int LW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int EW    = 4 * COORD_BITS;

	logic [EW-1:0] mem [MAX_BOXES];

	logic [COUNT_W-1:0]           box_count_q;
	logic signed [COORD_BITS-1:0] q_lo_x_q, q_lo_y_q, q_hi_x_q, q_hi_y_q;
	logic                         contain_q;
	logic [CNT_W-1:0]             limit_q;
	logic [CNT_W-1:0]             rd_ptr_q;
	logic                         found_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic                         rd_valid_s1;
	logic [AW-1:0]                rd_idx_s1;
	logic [EW-1:0]                entry_s1;
	logic                         res_hit_q;
	logic [IDX_W-1:0]             res_idx_q;

	logic [LW-1:0]                limit_w;
	logic                         slot_ok;
	logic signed [COORD_BITS-1:0] w_lo_x, w_hi_x, w_lo_y, w_hi_y;
	logic signed [COORD_BITS-1:0] b_lo_x, b_lo_y, b_hi_x, b_hi_y;
	logic                         meets, holds, match, issue;

	// Clamp the scan length to the table depth
	assign limit_w = (LW'(box_count_q) > LW'(MAX_BOXES)) ? LW'(MAX_BOXES) : LW'(box_count_q);
	assign slot_ok = (int'(entry_index) < MAX_BOXES);

	// Normalize an entry on its way into the table
	assign w_lo_x = (left_edge <= right_edge) ? left_edge : right_edge;
	assign w_hi_x = (left_edge <= right_edge) ? right_edge : left_edge;
	assign w_lo_y = (top_edge <= bottom_edge) ? top_edge : bottom_edge;
	assign w_hi_y = (top_edge <= bottom_edge) ? bottom_edge : top_edge;

	assign b_lo_x = entry_s1[0*COORD_BITS +: COORD_BITS];
	assign b_lo_y = entry_s1[1*COORD_BITS +: COORD_BITS];
	assign b_hi_x = entry_s1[2*COORD_BITS +: COORD_BITS];
	assign b_hi_y = entry_s1[3*COORD_BITS +: COORD_BITS];

	assign meets = (q_lo_x_q <= b_hi_x) && (b_lo_x <= q_hi_x_q) &&
		(q_lo_y_q <= b_hi_y) && (b_lo_y <= q_hi_y_q);
	assign holds = (q_lo_x_q >= b_lo_x) && (q_hi_x_q <= b_hi_x) &&
		(q_lo_y_q >= b_lo_y) && (q_hi_y_q <= b_hi_y);
	assign match = rd_valid_s1 && !found_q && (contain_q ? holds : meets);

	assign issue = cmd.scan_run && !found_q && !match && (rd_ptr_q < limit_q);

	// Only looked at by the controller while it scans
	always_comb begin
		status           = '0;
		status.scan_done = !rd_valid_s1 && (found_q || (rd_ptr_q == limit_q));
	end

	assign hit       = res_hit_q;
	assign hit_index = res_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.write_en && slot_ok) begin
			mem[AW'(entry_index)] <= {w_hi_y, w_hi_x, w_lo_y, w_lo_x};
		end
	end

	always_ff @(posedge clk) begin
		entry_s1  <= mem[rd_ptr_q[AW-1:0]];
		rd_idx_s1 <= rd_ptr_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			rd_ptr_q    <= '0;
		end else begin
			if (cfg_we) begin
				box_count_q <= cfg_data;
			end
			if (cmd.query_start) begin
				found_q     <= 1'b0;
				rd_ptr_q    <= '0;
				rd_valid_s1 <= 1'b0;
			end else begin
				rd_valid_s1 <= issue;
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			q_lo_x_q  <= left_edge;
			q_lo_y_q  <= top_edge;
			q_hi_x_q  <= right_edge;
			q_hi_y_q  <= bottom_edge;
			contain_q <= (req_type == REQ_CONTAIN);
			limit_q   <= CNT_W'(limit_w);
			hit_idx_q <= '0;
		end else if (match) begin
			hit_idx_q <= IDX_W'(rd_idx_s1);
		end
		if (cmd.result_load) begin
			res_hit_q <= found_q;
			res_idx_q <= hit_idx_q;
		end
	end

endmodule
